@@ design/multi_timer_deadline_scheduler_top_assert.svh @@
// Assertion macros for the timer bank top level.
// Used only by multi_timer_deadline_scheduler_top.sv.
`ifndef MULTI_TIMER_DEADLINE_SCHEDULER_TOP_ASSERT_SVH
`define MULTI_TIMER_DEADLINE_SCHEDULER_TOP_ASSERT_SVH

// a implies b in the same cycle
`define MTDS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");

// a implies b in the next cycle
`define MTDS_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");

`endif

@@ design/mtds_pkg.sv @@
// Shared types and constants for the timer bank.
// No dependencies.
package mtds_pkg;
    localparam int NUM_TIMERS = 16;
    localparam int ID_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [62:0] MAX63 = {63{1'b1}};
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    typedef enum logic [1:0] {
        CMD_START_PER = 2'd0,
        CMD_START_ONE = 2'd1,
        CMD_STOP      = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    // token circulating through the cells
    typedef struct packed {
        logic        hit;      // a due timer found so far
        logic [62:0] best_dl;
        logic [7:0]  best_id;
        logic        pend;     // any armed timer seen
        logic [62:0] min_dl;
    } scan_t;

    // control broadcast to all cells
    typedef struct packed {
        logic        wr;       // write start/stop to sel_id
        logic [7:0]  sel_id;
        logic        arm;
        logic [62:0] dl;
        logic [30:0] per;
        logic        fire;     // expire fire_id: rearm or stop
        logic [7:0]  fire_id;
        logic [62:0] rearm_dl;
        logic        clr_fired;
    } cell_ctl_t;
endpackage

@@ design/mtds_cell.sv @@
// One timer cell: holds deadline, period, armed and fired bits.
// Folds its timer into the scan token and passes it on. Uses mtds_pkg.
module mtds_cell
    import mtds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  my_id,
    input  cell_ctl_t   ctl,
    input  logic [62:0] now,
    input  scan_t       tok_in,
    output scan_t       tok_out,
    output logic [30:0] per_out
);
    logic [62:0] dl_reg;
    logic [30:0] per_reg;
    logic        armed_reg;
    logic        fired_reg;
    logic        due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg    <= '0;
            per_reg   <= '0;
            armed_reg <= 1'b0;
            fired_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_fired)
                fired_reg <= 1'b0;
            if (ctl.wr && ctl.sel_id == my_id)
            begin
                armed_reg <= ctl.arm;
                if (ctl.arm)
                begin
                    dl_reg  <= ctl.dl;
                    per_reg <= ctl.per;
                end
            end
            if (ctl.fire && ctl.fire_id == my_id)
            begin
                fired_reg <= 1'b1;
                if (per_reg != '0)
                    dl_reg <= ctl.rearm_dl;
                else
                    armed_reg <= 1'b0;
            end
        end
    end

    assign per_out = per_reg;
    assign due = armed_reg && !fired_reg && dl_reg <= now;

    always_comb
    begin
        tok_out = tok_in;
        if (due && (!tok_in.hit || dl_reg < tok_in.best_dl))
        begin
            tok_out.hit     = 1'b1;
            tok_out.best_dl = dl_reg;
            tok_out.best_id = my_id;
        end
        if (armed_reg && (!tok_in.pend || dl_reg < tok_in.min_dl))
        begin
            tok_out.pend   = 1'b1;
            tok_out.min_dl = dl_reg;
        end
    end
endmodule

@@ design/mtds_chain.sv @@
// Row of timer cells with a register after every fourth cell.
// Uses mtds_pkg and mtds_cell.
module mtds_chain
    import mtds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  logic [62:0] now,
    input  logic [7:0]  per_sel,
    output scan_t       result,
    output logic [30:0] per_at
);
    localparam int GRP = 4;
    scan_t       tin  [NUM_TIMERS];
    scan_t       tout [NUM_TIMERS];
    scan_t       stage_reg [NUM_TIMERS];
    logic [30:0] pers [NUM_TIMERS];

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign tin[g] = '0;
            end
            else if (g % GRP == 0)
            begin : g_reg
                assign tin[g] = stage_reg[g - 1];
            end
            else
            begin : g_wire
                assign tin[g] = tout[g - 1];
            end
            always_ff @(posedge clk)
                stage_reg[g] <= tout[g];
            mtds_cell u_cell (
                .clk(clk), .rst_n(rst_n), .my_id(8'(g)), .ctl(ctl), .now(now),
                .tok_in(tin[g]), .tok_out(tout[g]), .per_out(pers[g])
            );
        end
    endgenerate

    assign result = stage_reg[NUM_TIMERS - 1];
    assign per_at = pers[per_sel[ID_W-1:0]];
endmodule

@@ design/multi_timer_deadline_scheduler_top.sv @@
// Channel  Dir  tdata                                                tuser
// s_axis   in   command[1:0] timer_id[5:2] interval[36:6] time[99:37]  -
// m_axis   out  expired_valid[0] id[4:1] pending[5] next_dl[68:6]     -   (last on tlast)
// One item at a time. Each scan waits until the four register stages of the cell
// row settle. Start/stop: accept, one write, one scan, one result.
// Tick: a write and a scan, then a fire and a scan per expired timer, then one
// result per expired id, or one result if none expired. Expired ids are listed and
// sent after the final scan; a held result stalls the input. Reset clears all timers.
module multi_timer_deadline_scheduler_top
    import mtds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // command, timer_id, interval_ms, time_ns
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // expired_valid, expired_id, any_pending, next_deadline
    output logic         m_axis_tlast
);
    localparam int SCAN = NUM_TIMERS / 4 + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WR    = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FIRE  = 5'b01000,
        S_OUT   = 5'b10000
    } st_t;

    st_t         st_reg, st_next;
    cmd_t        cmd_reg;
    logic [3:0]  id_reg;
    logic [30:0] ivl_reg;
    logic [62:0] now_reg;
    logic [3:0]  wait_reg;
    logic [4:0]  nexp_reg;
    logic        ovld_reg;
    logic [71:0] odata_reg;
    logic        olast_reg;
    logic [7:0]  fid_reg;
    logic [62:0] prod_reg;
    logic [3:0]  exp_ids_reg [NUM_TIMERS];
    logic [4:0]  oidx_reg;
    logic [63:0] sum;
    logic [50:0] start_prod;
    logic [50:0] rearm_prod;
    cell_ctl_t   ctl;
    scan_t       res;
    logic [30:0] per_at;
    logic [62:0] sat_start;

    // period of the timer about to fire is looked up while the scan result is held
    mtds_chain u_chain (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .now(now_reg), .per_sel(res.best_id),
        .result(res), .per_at(per_at)
    );

    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    assign start_prod = 51'(s_axis_tdata[36:6]) * 51'(NS_PER_MS);
    assign rearm_prod = 51'(per_at) * 51'(NS_PER_MS);
    assign sum        = {1'b0, now_reg} + {1'b0, prod_reg};
    assign sat_start  = sum[63] ? MAX63 : sum[62:0];

    always_comb
    begin
        ctl          = '0;
        ctl.sel_id   = {4'd0, id_reg};
        ctl.fire_id  = fid_reg;
        ctl.rearm_dl = sat_start;
        ctl.per      = ivl_reg;
        if (st_reg == S_WR)
        begin
            unique case (cmd_reg)
                CMD_START_PER:
                begin
                    ctl.wr  = (ivl_reg != '0);
                    ctl.arm = 1'b1;
                    ctl.dl  = sat_start;
                end
                CMD_START_ONE:
                begin
                    ctl.wr  = 1'b1;
                    ctl.arm = 1'b1;
                    ctl.dl  = now_reg;
                    ctl.per = '0;
                end
                CMD_STOP:
                    ctl.wr = 1'b1;
                CMD_TICK:
                    ctl.clr_fired = 1'b1;
                default: ;
            endcase
        end
        if (st_reg == S_FIRE)
            ctl.fire = 1'b1;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:  if (s_axis_tvalid) st_next = S_WR;
            S_WR:    st_next = S_SCAN;
            S_SCAN:
                if (wait_reg == '0)
                begin
                    if (cmd_reg == CMD_TICK && res.hit && nexp_reg < 5'd16)
                        st_next = S_FIRE;
                    else
                        st_next = S_OUT;
                end
            S_FIRE:  st_next = S_SCAN;
            S_OUT:   if (ovld_reg && m_axis_tready && olast_reg) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ovld_reg <= 1'b0;
            wait_reg <= '0;
            nexp_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_SCAN && st_next == S_OUT)
                ovld_reg <= 1'b1;
            else if (ovld_reg && m_axis_tready && olast_reg)
                ovld_reg <= 1'b0;
            if (st_reg == S_WR || st_reg == S_FIRE)
                wait_reg <= 4'(SCAN);
            else if (wait_reg != '0)
                wait_reg <= wait_reg - 4'd1;
            if (st_reg == S_IDLE)
                nexp_reg <= '0;
            else if (st_reg == S_SCAN && st_next == S_FIRE)
                nexp_reg <= nexp_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && s_axis_tvalid)
        begin
            cmd_reg  <= cmd_t'(s_axis_tdata[1:0]);
            id_reg   <= s_axis_tdata[5:2];
            ivl_reg  <= s_axis_tdata[36:6];
            now_reg  <= s_axis_tdata[99:37];
            prod_reg <= 63'(start_prod);
        end
        if (st_reg == S_SCAN && st_next == S_FIRE)
        begin
            fid_reg                      <= res.best_id;
            exp_ids_reg[nexp_reg[3:0]]   <= res.best_id[3:0];
            prod_reg                     <= 63'(rearm_prod);
        end
        // all results of an item carry the state after the final scan
        if (st_reg == S_SCAN && st_next == S_OUT)
        begin
            oidx_reg  <= 5'd1;
            olast_reg <= (nexp_reg <= 5'd1);
            if (nexp_reg != '0)
                odata_reg <= {3'd0, res.pend ? res.min_dl : 63'd0, res.pend,
                              exp_ids_reg[0], 1'b1};
            else
                odata_reg <= {3'd0, res.pend ? res.min_dl : 63'd0, res.pend,
                              4'd0, 1'b0};
        end
        if (st_reg == S_OUT && ovld_reg && m_axis_tready && !olast_reg)
        begin
            odata_reg[4:1] <= exp_ids_reg[oidx_reg[3:0]];
            olast_reg      <= (oidx_reg == nexp_reg - 5'd1);
            oidx_reg       <= oidx_reg + 5'd1;
        end
    end

    `include "multi_timer_deadline_scheduler_top_assert.svh"

    `MTDS_ASSERT_IMP(a_ready_idle, s_axis_tready, !ovld_reg)
    `MTDS_ASSERT_NXT(a_fire_scan, st_reg == S_FIRE, st_reg == S_SCAN)
    `MTDS_ASSERT_IMP(a_cap, st_reg == S_FIRE, nexp_reg <= 5'd16)
    `MTDS_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
